// ----- hw/rtl/bpdft_pkg.sv -----
// shared types, constants and rounding helpers for the baseline phasor dft generator
`default_nettype none
package bpdft_pkg;

	localparam int MAX_CHANNELS_DEF = 64;
	localparam int PH_W  = 16;   // Q1.15 phasor width
	localparam int VAL_W = 24;   // Q8.15 value width
	localparam int CFG_W = 7;    // channel_count register width
	localparam int PRD_W = VAL_W + PH_W;   // one product
	localparam int ACC_W = PRD_W + 1;      // sum of two products
	localparam int P_W   = 2 * PH_W + 1;   // exact phasor cross product
	localparam int QDIV_W = P_W;           // dividend and quotient width
	localparam int DCNT_W = $clog2(QDIV_W + 1);

	// multiply sequence: terms 0..3 issue, 1..4 accumulate, 5 stores (rounded except for the start cross product)
	localparam logic [2:0] PH_FIRST = 3'd0;
	localparam logic [2:0] PH_STORE = 3'd5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START_MUL,
		S_STEP_MUL,
		S_DIV_RE,
		S_DIV_IM,
		S_EMIT,
		S_NEXT_MUL
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// floor((a + 2^14) / 2^15), saturated to the Q8.15 range
	function automatic logic signed [VAL_W-1:0] rnd_sat_val(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] biased;
		logic signed [ACC_W:0] sh;
		biased = (ACC_W+1)'(a) + (ACC_W+1)'(16384);
		sh = biased >>> 15;
		if (sh > (ACC_W+1)'(8388607)) begin
			return 24'sh7FFFFF;
		end else if (sh < -(ACC_W+1)'(8388608)) begin
			return 24'sh800000;
		end else begin
			return sh[VAL_W-1:0];
		end
	endfunction

	// same rounding, saturated to Q1.15
	function automatic logic signed [PH_W-1:0] rnd_sat_ph(input logic signed [ACC_W-1:0] a);
		logic signed [ACC_W:0] biased;
		logic signed [ACC_W:0] sh;
		biased = (ACC_W+1)'(a) + (ACC_W+1)'(16384);
		sh = biased >>> 15;
		if (sh > (ACC_W+1)'(32767)) begin
			return 16'sh7FFF;
		end else if (sh < -(ACC_W+1)'(32768)) begin
			return 16'sh8000;
		end else begin
			return sh[PH_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bpdft_if.sv -----
// valid/ready channel interfaces for time slots in and channel terms out
`default_nettype none
interface bpdft_slot_if
	import bpdft_pkg::*;
	;
	logic                   valid;
	logic                   ready;
	logic signed [PH_W-1:0] left_start_re;
	logic signed [PH_W-1:0] left_start_im;
	logic signed [PH_W-1:0] right_start_re;
	logic signed [PH_W-1:0] right_start_im;
	logic signed [PH_W-1:0] left_step_re;
	logic signed [PH_W-1:0] left_step_im;
	logic signed [PH_W-1:0] right_step_re;
	logic signed [PH_W-1:0] right_step_im;
	logic [PH_W-1:0]        direction_n;

	modport source (
		output valid, left_start_re, left_start_im, right_start_re, right_start_im,
		       left_step_re, left_step_im, right_step_re, right_step_im, direction_n,
		input  ready
	);
	modport sink (
		input  valid, left_start_re, left_start_im, right_start_re, right_start_im,
		       left_step_re, left_step_im, right_step_re, right_step_im, direction_n,
		output ready
	);
endinterface

interface bpdft_term_if
	import bpdft_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] value_re;
	logic signed [VAL_W-1:0] value_im;
	logic                    last_channel;

	modport source (
		output valid, value_re, value_im, last_channel,
		input  ready
	);
	modport sink (
		input  valid, value_re, value_im, last_channel,
		output ready
	);
endinterface
`default_nettype wire

// ----- hw/rtl/baseline_phasor_dft_generator_unit.sv -----
// top level: baseline phasor dft generator on one shared multiplier and a serial divider
//
//  channel      dir   kind         payload
//  slot         in    valid/ready  start and step phasors of both stations, direction_n
//  term         out   valid/ready  value_re, value_im (Q8.15), last_channel
//  cfg_wr_*     in    write only   channel_count (7 bit)
//
//  one time slot: transfer, start cross product, step product, two divides by n, load of
//  the first term, then for each further channel 4 products on the shared 24x16
//  multiplier plus accumulate and round. the single multiplier sets the channel rate.
//  reset clears the sequencer, the running value and step, and sets channel_count to 1.
//  a stalled term side holds the result in the output register while the next
//  channel is computed; the last term of a slot may wait there while a new slot transfers.
`default_nettype none
module baseline_phasor_dft_generator_unit
	import bpdft_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [CFG_W-1:0] cfg_wr_data,
	bpdft_slot_if.sink            slot,
	bpdft_term_if.source          term
);

	localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
	localparam int CMP_W = (CH_W > CFG_W) ? CH_W : CFG_W;

	// sequencer
	state_t     state_q;
	state_t     state_d;
	logic [2:0] phase_q;
	logic       slot_xfer;
	logic       term_free;
	logic       emit_load;
	logic       mul_state;
	logic       last_ch;

	// configuration and channel count
	logic [CFG_W-1:0] chan_cnt_q;
	logic [CMP_W-1:0] eff_cmp;
	logic [CH_W-1:0]  eff_count;
	logic [CH_W-1:0]  ch_idx_q;

	// captured slot payload
	logic signed [PH_W-1:0] lsr_q, lsi_q, rsr_q, rsi_q;
	logic signed [PH_W-1:0] ldr_q, ldi_q, rdr_q, rdi_q;
	logic [PH_W-1:0]        n_q;

	// arithmetic state
	logic signed [VAL_W-1:0] run_re_q, run_im_q;
	logic signed [PH_W-1:0]  step_re_q, step_im_q;
	logic signed [P_W-1:0]   p_re_q, p_im_q;

	// shared multiplier and accumulator
	logic [1:0]              term_idx;
	logic signed [VAL_W-1:0] x_re, x_im, op_a;
	logic signed [PH_W-1:0]  y_re, y_im, op_b;
	logic signed [PRD_W-1:0] prod_s1;
	logic [1:0]              tag_s1;
	logic                    acc_en_s1;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic signed [ACC_W-1:0] prod_ext;
	logic                    sub_term;

	// divider hookup
	logic                    div_start;
	logic signed [P_W-1:0]   p_sel;
	logic [QDIV_W-1:0]       p_mag;
	logic [QDIV_W-1:0]       dividend;
	div_stat_t               div_stat;
	logic [QDIV_W-1:0]       quotient;
	logic signed [VAL_W-1:0] div_val;
	logic signed [P_W-1:0]   p_done;
	logic                    q_sat;
	logic signed [VAL_W-1:0] q_pos;

	// output register
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] out_re_q, out_im_q;
	logic                    out_last_q;

	// effective channel count: zero means one, above the maximum means the maximum
	always_comb begin
		if (chan_cnt_q == '0) begin
			eff_cmp = CMP_W'(1);
		end else if (CMP_W'(chan_cnt_q) > CMP_W'(MAX_CHANNELS)) begin
			eff_cmp = CMP_W'(MAX_CHANNELS);
		end else begin
			eff_cmp = CMP_W'(chan_cnt_q);
		end
	end
	assign eff_count = eff_cmp[CH_W-1:0];
	assign last_ch   = CH_W'(ch_idx_q + 1'b1) == eff_count;

	assign slot_xfer = slot.valid && slot.ready;
	assign term_free = !out_valid_q || term.ready;
	assign mul_state = (state_q == S_START_MUL) || (state_q == S_STEP_MUL)
	                || (state_q == S_NEXT_MUL);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (slot.valid) state_d = S_START_MUL;
			end
			S_START_MUL: begin
				if (phase_q == PH_STORE) state_d = S_STEP_MUL;
			end
			S_STEP_MUL: begin
				if (phase_q == PH_STORE) state_d = S_DIV_RE;
			end
			S_DIV_RE: begin
				if (div_stat.done) state_d = S_DIV_IM;
			end
			S_DIV_IM: begin
				if (div_stat.done) state_d = S_EMIT;
			end
			S_EMIT: begin
				if (term_free) state_d = last_ch ? S_IDLE : S_NEXT_MUL;
			end
			S_NEXT_MUL: begin
				if (phase_q == PH_STORE) state_d = S_EMIT;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		slot.ready = 1'b0;
		emit_load  = 1'b0;
		div_start  = 1'b0;
		p_sel      = p_re_q;
		unique case (state_q)
			S_IDLE:   slot.ready = 1'b1;
			S_STEP_MUL: begin
				div_start = phase_q == PH_STORE;
				p_sel     = p_re_q;
			end
			S_DIV_RE: begin
				div_start = div_stat.done;
				p_sel     = p_im_q;
			end
			S_EMIT:   emit_load = term_free;
			default: begin
				slot.ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= PH_FIRST;
			chan_cnt_q <= CFG_W'(1);
			ch_idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) chan_cnt_q <= cfg_wr_data;
			if (mul_state && phase_q != PH_STORE) begin
				phase_q <= phase_q + 1'b1;
			end else begin
				phase_q <= PH_FIRST;
			end
			if (emit_load) begin
				ch_idx_q <= last_ch ? '0 : CH_W'(ch_idx_q + 1'b1);
			end
		end
	end

	// capture the slot on transfer
	always_ff @(posedge clk) begin
		if (slot_xfer) begin
			lsr_q <= slot.left_start_re;
			lsi_q <= slot.left_start_im;
			rsr_q <= slot.right_start_re;
			rsi_q <= slot.right_start_im;
			ldr_q <= slot.left_step_re;
			ldi_q <= slot.left_step_im;
			rdr_q <= slot.right_step_re;
			rdi_q <= slot.right_step_im;
			n_q   <= slot.direction_n;
		end
	end

	// operand select: terms 0,1 build the real part and 2,3 the imaginary part
	// X * conj(Y) or X * Y share the pattern a=(Xr,Xi,Xi,Xr), b=(Yr,Yi,Yr,Yi)
	assign term_idx = phase_q[1:0];
	always_comb begin
		x_re = VAL_W'(rsr_q);
		x_im = VAL_W'(rsi_q);
		y_re = lsr_q;
		y_im = lsi_q;
		unique case (state_q)
			S_STEP_MUL: begin
				x_re = VAL_W'(rdr_q);
				x_im = VAL_W'(rdi_q);
				y_re = ldr_q;
				y_im = ldi_q;
			end
			S_NEXT_MUL: begin
				x_re = run_re_q;
				x_im = run_im_q;
				y_re = step_re_q;
				y_im = step_im_q;
			end
			default: begin
				x_re = VAL_W'(rsr_q);
			end
		endcase
		op_a = (term_idx == 2'd0 || term_idx == 2'd3) ? x_re : x_im;
		op_b = term_idx[0] ? y_im : y_re;
	end

	// conjugate pass subtracts Xr*Yi, recurrence pass subtracts Xi*Yi
	assign sub_term = (state_q == S_NEXT_MUL) ? (tag_s1 == 2'd1) : (tag_s1 == 2'd3);
	assign prod_ext = ACC_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= mul_state && !phase_q[2];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
		tag_s1  <= term_idx;
		if (mul_state && phase_q == PH_FIRST) begin
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (acc_en_s1) begin
			if (tag_s1[1]) begin
				acc_im_q <= sub_term ? acc_im_q - prod_ext : acc_im_q + prod_ext;
			end else begin
				acc_re_q <= sub_term ? acc_re_q - prod_ext : acc_re_q + prod_ext;
			end
		end
	end

	// cross product results of the slot
	always_ff @(posedge clk) begin
		if (state_q == S_START_MUL && phase_q == PH_STORE) begin
			p_re_q <= acc_re_q[P_W-1:0];
			p_im_q <= acc_im_q[P_W-1:0];
		end
	end

	// rounded division of |P| by n, sign restored and saturated
	assign p_mag    = p_sel[P_W-1] ? QDIV_W'(-p_sel) : QDIV_W'(p_sel);
	assign dividend = p_mag + QDIV_W'(n_q >> 1);

	bpdft_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (n_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	assign p_done = (state_q == S_DIV_IM) ? p_im_q : p_re_q;
	assign q_sat  = |quotient[QDIV_W-1:VAL_W-1];
	assign q_pos  = {1'b0, quotient[VAL_W-2:0]};

	always_comb begin
		if (n_q == '0) begin
			// zero divisor saturates toward the sign of P
			if (p_done == '0) begin
				div_val = '0;
			end else if (p_done[P_W-1]) begin
				div_val = 24'sh800000;
			end else begin
				div_val = 24'sh7FFFFF;
			end
		end else if (p_done[P_W-1]) begin
			div_val = q_sat ? 24'sh800000 : -q_pos;
		end else begin
			div_val = q_sat ? 24'sh7FFFFF : q_pos;
		end
	end

	// running value and step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_re_q  <= '0;
			run_im_q  <= '0;
			step_re_q <= '0;
			step_im_q <= '0;
		end else begin
			if (state_q == S_STEP_MUL && phase_q == PH_STORE) begin
				step_re_q <= rnd_sat_ph(acc_re_q);
				step_im_q <= rnd_sat_ph(acc_im_q);
			end
			if (state_q == S_DIV_RE && div_stat.done) run_re_q <= div_val;
			if (state_q == S_DIV_IM && div_stat.done) run_im_q <= div_val;
			if (state_q == S_NEXT_MUL && phase_q == PH_STORE) begin
				run_re_q <= rnd_sat_val(acc_re_q);
				run_im_q <= rnd_sat_val(acc_im_q);
			end
		end
	end

	// output register, loaded when free or emptied in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (term.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_re_q   <= run_re_q;
			out_im_q   <= run_im_q;
			out_last_q <= last_ch;
		end
	end

	assign term.valid        = out_valid_q;
	assign term.value_re     = out_re_q;
	assign term.value_im     = out_im_q;
	assign term.last_channel = out_last_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bpdft_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
`default_nettype none
module bpdft_div
	import bpdft_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [QDIV_W-1:0] dividend,
	input  wire logic [PH_W-1:0]   divisor,
	output div_stat_t              stat,
	output logic [QDIV_W-1:0]      quotient
);

	logic [QDIV_W-1:0] quo_q;
	logic [PH_W-1:0]   rem_q;
	logic [PH_W-1:0]   div_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PH_W:0]     trial;
	logic [PH_W:0]     diff;
	logic              ge;

	assign trial = {rem_q, quo_q[QDIV_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(QDIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[QDIV_W-2:0], ge};
			rem_q <= ge ? diff[PH_W-1:0] : trial[PH_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire
